/* hdl/crps_pkg.sv */
// ---------------------------------------------------------------------------
// crps_pkg: shared types and codes of the counted row page store
// Command and status codes and the request and response transfer structs.
// ---------------------------------------------------------------------------
package crps_pkg;

   // command codes
   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_REMOVE = 3'd1;
   localparam logic [2:0] CMD_SORT   = 3'd2;
   localparam logic [2:0] CMD_SHRINK = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_UNUSED = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  slot;
      logic [63:0] row_key;
      logic [63:0] row_value;
      logic [31:0] row_counter;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  result_slot;
      logic        moved;
      logic [7:0]  moved_from;
      logic [8:0]  used_count;
      logic [63:0] out_key;
      logic [63:0] out_value;
      logic [31:0] out_counter;
   } rsp_type;

endpackage

/* hdl/crps_row_ram.sv */
// ---------------------------------------------------------------------------
// crps_row_ram: row storage
// 256-entry single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module crps_row_ram #(
   parameter int ROW_BITS = 160
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [7:0]          wr_addr,
   input  logic [ROW_BITS-1:0] wr_data,
   input  logic [7:0]          rd_addr,
   output logic [ROW_BITS-1:0] rd_data
);

   logic [ROW_BITS-1:0] mem [256];
   logic [ROW_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/counted_row_page_store.sv */
// Add goes S_IDLE, S_DISP, S_DONE from request transfer to response valid; remove and read
// also pass S_RMW or S_RDAT. Sort and shrink walk the row RAM in shell passes; a sort of
// a store already marked sorted goes from S_DISP through S_FINISH to S_DONE.
// Throughput: one command at a time; the next request is taken once the response is queued.
// Reset (synchronous): rows used 0, one page, store marked sorted; row RAM is not cleared.
// ---------------------------------------------------------------------------
// counted_row_page_store: row store with use counters and shell sort
// Sequencer around one row RAM that adds, removes, reads, sorts by descending counter
// and shrinks the page allocation after a sort, keeping the higher-counter half of the rows.
// ---------------------------------------------------------------------------
module counted_row_page_store
   import crps_pkg::*;
#(
   parameter int ROWS_PER_PAGE = 16,
   parameter int MAX_PAGES     = 16,
   parameter int KEY_BITS      = 64,
   parameter int VALUE_BITS    = 64,
   parameter int COUNTER_BITS  = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int ROW_BITS = KEY_BITS + VALUE_BITS + COUNTER_BITS;
   localparam int PW       = $clog2(MAX_PAGES + 1) + 1;
   localparam int CW       = PW + 9;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_RMW    = 4'd2;
   localparam logic [3:0] S_RDAT   = 4'd3;
   localparam logic [3:0] S_HCALC  = 4'd4;
   localparam logic [3:0] S_IINIT  = 4'd5;
   localparam logic [3:0] S_ICHK   = 4'd6;
   localparam logic [3:0] S_HELD   = 4'd7;
   localparam logic [3:0] S_CMP    = 4'd8;
   localparam logic [3:0] S_NEXT   = 4'd9;
   localparam logic [3:0] S_FINISH = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   logic [3:0]          state_ff, state_in;
   req_type             req_ff, req_in;
   logic [8:0]          used_ff, used_in;
   logic [PW-1:0]       pages_ff, pages_in;
   logic                sorted_ff, sorted_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [8:0]          h_ff, h_in;
   logic [8:0]          i_ff, i_in;
   logic [8:0]          j_ff, j_in;
   logic [ROW_BITS-1:0] held_ff, held_in;

   logic                wr_en;
   logic [7:0]          wr_addr;
   logic [ROW_BITS-1:0] wr_data;
   logic [7:0]          rd_addr;
   logic [ROW_BITS-1:0] rd_data;

   logic [8:0]          cap_cur;
   logic [8:0]          cap_new;
   logic [PW-1:0]       pages_grow;
   logic [PW-1:0]       pages_add;
   logic                out_free;
   logic [12:0]         h_probe;
   logic [17:0]         h_div;
   logic [8:0]          j_dec;

   // rows held by a page count, limited to the RAM depth
   function automatic logic [8:0] cap_of(input logic [PW-1:0] p);
      logic [CW-1:0] prod;
      prod = CW'(p) * CW'(ROWS_PER_PAGE);
      return (prod > CW'(256)) ? 9'd256 : prod[8:0];
   endfunction

   function automatic logic [COUNTER_BITS-1:0] cnt_of(input logic [ROW_BITS-1:0] r);
      return r[COUNTER_BITS-1:0];
   endfunction

   crps_row_ram #(.ROW_BITS(ROW_BITS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // add: allocation growth
   always_comb begin
      cap_cur    = cap_of(pages_ff);
      pages_grow = pages_ff + (pages_ff >> 1) + PW'(1);
      if (pages_grow > PW'(MAX_PAGES)) begin
         pages_grow = PW'(MAX_PAGES);
      end
      if (used_ff >= cap_cur && pages_ff < PW'(MAX_PAGES) && cap_cur < 9'd256) begin
         pages_add = pages_grow;
      end else begin
         pages_add = pages_ff;
      end
      cap_new = cap_of(pages_add);
   end

   // sort helpers: gap probe, gap / 3 by reciprocal, hole step
   assign h_probe  = 13'(h_ff) * 13'd9 + 13'd4;
   assign h_div    = 18'(h_ff) * 18'd171;
   assign j_dec    = j_ff - h_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      used_in      = used_ff;
      pages_in     = pages_ff;
      sorted_in    = sorted_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      h_in         = h_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      held_in      = held_ff;
      wr_en        = 1'b0;
      wr_addr      = 8'd0;
      wr_data      = rd_data;
      rd_addr      = 8'd0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            res_in   = '0;
            state_in = S_DONE;
            unique case (req_ff.cmd)
               CMD_ADD: begin
                  pages_in = pages_add;
                  if (used_ff >= cap_new) begin
                     res_in.status = STAT_FULL;
                  end else begin
                     wr_en              = 1'b1;
                     wr_addr            = used_ff[7:0];
                     wr_data            = {req_ff.row_key[KEY_BITS-1:0],
                                           req_ff.row_value[VALUE_BITS-1:0],
                                           req_ff.row_counter[COUNTER_BITS-1:0]};
                     res_in.result_slot = used_ff[7:0];
                     used_in            = used_ff + 9'd1;
                     sorted_in          = 1'b0;
                  end
               end
               CMD_REMOVE: begin
                  if (9'(req_ff.slot) >= used_ff) begin
                     res_in.status = STAT_UNUSED;
                  end else begin
                     rd_addr  = 8'(used_ff - 9'd1);
                     state_in = S_RMW;
                  end
               end
               CMD_READ: begin
                  if (9'(req_ff.slot) >= used_ff) begin
                     res_in.status = STAT_UNUSED;
                  end else begin
                     rd_addr  = req_ff.slot;
                     state_in = S_RDAT;
                  end
               end
               CMD_SORT, CMD_SHRINK: begin
                  if (req_ff.cmd == CMD_SHRINK && pages_ff <= PW'(1)) begin
                     state_in = S_DONE;
                  end else if (sorted_ff) begin
                     state_in = S_FINISH;
                  end else begin
                     h_in     = 9'd1;
                     state_in = S_HCALC;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         // last row arrives; fill the hole with it
         S_RMW: begin
            used_in            = used_ff - 9'd1;
            res_in.result_slot = req_ff.slot;
            if (used_ff != 9'd1) begin
               sorted_in = 1'b0;
               if (9'(req_ff.slot) != used_ff - 9'd1) begin
                  wr_en             = 1'b1;
                  wr_addr           = req_ff.slot;
                  wr_data           = rd_data;
                  res_in.moved      = 1'b1;
                  res_in.moved_from = 8'(used_ff - 9'd1);
               end
            end
            state_in = S_DONE;
         end
         S_RDAT: begin
            res_in.out_key     = 64'(rd_data[ROW_BITS-1 -: KEY_BITS]);
            res_in.out_value   = 64'(rd_data[COUNTER_BITS +: VALUE_BITS]);
            res_in.out_counter = 32'(cnt_of(rd_data));
            state_in           = S_DONE;
         end
         // largest gap h of the 3h+1 sequence with 3h+1 below the rows used
         S_HCALC: begin
            if (h_probe < 13'(used_ff)) begin
               h_in = 9'(3 * h_ff + 1);
            end else begin
               state_in = S_IINIT;
            end
         end
         S_IINIT: begin
            i_in     = h_ff + 9'd1;
            state_in = S_ICHK;
         end
         S_ICHK: begin
            if (i_ff <= used_ff) begin
               rd_addr  = 8'(i_ff - 9'd1);
               j_in     = i_ff;
               state_in = S_HELD;
            end else if (h_div[17:9] == 9'd0) begin
               state_in = S_FINISH;
            end else begin
               h_in     = h_div[17:9];
               state_in = S_IINIT;
            end
         end
         S_HELD: begin
            held_in  = rd_data;
            rd_addr  = 8'(j_ff - h_ff - 9'd1);
            state_in = S_CMP;
         end
         // shift the compared row up a gap or drop the held row
         S_CMP: begin
            if (cnt_of(held_ff) > cnt_of(rd_data)) begin
               wr_en   = 1'b1;
               wr_addr = 8'(j_ff - 9'd1);
               wr_data = rd_data;
               j_in    = j_dec;
               if (h_ff < j_dec) begin
                  rd_addr = 8'(j_dec - h_ff - 9'd1);
               end else begin
                  state_in = S_NEXT;
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = 8'(j_ff - 9'd1);
               wr_data  = held_ff;
               i_in     = i_ff + 9'd1;
               state_in = S_ICHK;
            end
         end
         S_NEXT: begin
            wr_en    = 1'b1;
            wr_addr  = 8'(j_ff - 9'd1);
            wr_data  = held_ff;
            i_in     = i_ff + 9'd1;
            state_in = S_ICHK;
         end
         S_FINISH: begin
            sorted_in = 1'b1;
            if (req_ff.cmd == CMD_SHRINK) begin
               used_in  = used_ff >> 1;
               pages_in = (pages_ff >> 1) + PW'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in            = res_ff;
               rsp_in.used_count = used_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= 9'd0;
         pages_ff     <= PW'(1);
         sorted_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pages_ff     <= pages_in;
         sorted_ff    <= sorted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      h_ff    <= h_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      held_ff <= held_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_used_in_cap: assert property (@(posedge clock) disable iff (reset)
      used_ff <= cap_cur)
      else $error("rows used beyond page capacity");

   a_pages_range: assert property (@(posedge clock) disable iff (reset)
      pages_ff >= PW'(1) && pages_ff <= PW'(MAX_PAGES))
      else $error("page count out of range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside completion");

   a_sort_gap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (h_ff < j_ff && j_ff <= used_ff))
      else $error("sort hole index out of range");
`endif

endmodule
